>>> hdl/pfpm_pkg.sv
package pfpm_pkg;

    localparam int FRAMES  = 64;
    localparam int FRAME_W = 6;
    localparam int CNT_W   = 7;
    localparam int PAGE_W  = 32;
    localparam int CMD_W   = 2;
    localparam int ST_W    = 3;
    localparam int LANES   = 4;
    localparam int LANE_W  = 2;
    localparam int ROWS    = FRAMES / LANES;
    localparam int ROW_W   = FRAME_W - LANE_W;

    localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FETCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPIN = 2'd2;

    localparam logic [ST_W-1:0] ST_HIT       = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_NEW       = 3'd2;
    localparam logic [ST_W-1:0] ST_REUSED    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_UNPINNED  = 3'd5;
    localparam logic [ST_W-1:0] ST_UNPIN_ERR = 3'd6;

    localparam logic [CNT_W-1:0] MAX_PAGES_RST = 7'd64;

    typedef struct packed {
        logic              hit;
        logic [LANE_W-1:0] lane;
    } t_match;

endpackage

>>> hdl/pfpm_ifs.sv
interface pfpm_req_if;
    import pfpm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [PAGE_W-1:0]    page_number;
    logic [FRAME_W-1:0]   frame_index;
    modport source (output valid, cmd, page_number, frame_index, input ready);
    modport sink (input valid, cmd, page_number, frame_index, output ready);
endinterface

interface pfpm_rsp_if;
    import pfpm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic [FRAME_W-1:0]   frame;
    modport source (output valid, status, frame, input ready);
    modport sink (input valid, status, frame, output ready);
endinterface

interface pfpm_cfg_if;
    import pfpm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CNT_W-1:0]     max_pages;
    modport source (output valid, max_pages, input ready);
    modport sink (input valid, max_pages, output ready);
endinterface

>>> hdl/pfpm_keys.sv
module pfpm_keys (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [pfpm_pkg::FRAME_W-1:0]   i_wr_frame,
    input  logic [pfpm_pkg::PAGE_W-1:0]    i_wr_page,
    input  logic [pfpm_pkg::ROW_W-1:0]     i_rd_row,
    input  logic [pfpm_pkg::LANES-1:0]     i_row_pinned,
    input  logic [pfpm_pkg::PAGE_W-1:0]    i_key,
    output pfpm_pkg::t_match               o_match
);
    import pfpm_pkg::*;

    logic [LANES-1:0][PAGE_W-1:0] mem [ROWS];
    logic [LANES-1:0][PAGE_W-1:0] r_rd_data;

    // one row of page numbers per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_frame[FRAME_W-1:LANE_W]][i_wr_frame[LANE_W-1:0]] <= i_wr_page;
        end
        r_rd_data <= mem[i_rd_row];
    end

    // compare lanes; lowest lane wins
    always_comb begin
        o_match = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (i_row_pinned[l] && (r_rd_data[l] == i_key)) begin
                o_match.hit  = 1'b1;
                o_match.lane = LANE_W'(l);
            end
        end
    end

endmodule

>>> hdl/pfpm_stack.sv
module pfpm_stack (
    input  logic                           i_clk,
    input  logic                           i_push,
    input  logic [pfpm_pkg::FRAME_W-1:0]   i_push_addr,
    input  logic [pfpm_pkg::FRAME_W-1:0]   i_push_frame,
    input  logic [pfpm_pkg::FRAME_W-1:0]   i_rd_addr,
    output logic [pfpm_pkg::FRAME_W-1:0]   o_rd_frame
);
    import pfpm_pkg::*;

    logic [FRAME_W-1:0] mem [FRAMES];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[i_push_addr] <= i_push_frame;
        end
        o_rd_frame <= mem[i_rd_addr];
    end

endmodule

>>> hdl/page_frame_pin_manager_core.sv
// Page frame pin manager. A get or fetch scans the key memory for the page, reading one
// row of four page numbers per cycle until a hit or the last row; a fetch miss then reuses
// a free frame or allocates a new one, an unpin frees a pinned frame, an unknown command
// reports not found. One request at a time; a result not yet taken holds the sequencer.
// Reset (synchronous, active low) clears pin bits, counters and the sequencer,
// and sets max_pages to 64; the key and free-stack memories need no clearing.
module page_frame_pin_manager_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfpm_req_if.sink    i_req,
    pfpm_rsp_if.source  o_rsp,
    pfpm_cfg_if.sink    i_cfg
);
    import pfpm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MISS  = 3'd2;
    localparam logic [2:0] S_UNPIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    logic [2:0]          r_state,        n_state;
    logic [CMD_W-1:0]    r_cmd,          n_cmd;
    logic [PAGE_W-1:0]   r_page,         n_page;
    logic [FRAME_W-1:0]  r_fi,           n_fi;
    logic [ROW_W-1:0]    r_rd_row,       n_rd_row;
    logic [ROW_W-1:0]    r_cmp_row,      n_cmp_row;
    logic                r_cmp_vld,      n_cmp_vld;
    logic [FRAMES-1:0]   r_pinned,       n_pinned;
    logic [CNT_W-1:0]    r_free_depth,   n_free_depth;
    logic [CNT_W-1:0]    r_alloc,        n_alloc;
    logic [CNT_W-1:0]    r_pinned_count, n_pinned_count;
    logic [CNT_W-1:0]    r_max_pages,    n_max_pages;
    logic [ST_W-1:0]     r_res_status,   n_res_status;
    logic [FRAME_W-1:0]  r_res_frame,    n_res_frame;
    logic                r_out_valid,    n_out_valid;
    logic [ST_W-1:0]     r_out_status,   n_out_status;
    logic [FRAME_W-1:0]  r_out_frame,    n_out_frame;

    logic                req_fire;
    logic                key_wr_en;
    logic [FRAME_W-1:0]  key_wr_frame;
    t_match              match;
    logic                stk_push;
    logic [FRAME_W-1:0]  stk_rd_frame;
    logic [CNT_W-1:0]    depth_dec;
    logic [CNT_W-1:0]    limit;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.frame  = r_out_frame;

    // top of the free stack is always presented; depth holds during the key scan
    assign depth_dec = r_free_depth - CNT_W'(1);

    // a limit above the pool size acts as the pool size
    assign limit = (r_max_pages > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : r_max_pages;

    pfpm_keys u_keys (
        .i_clk        (i_clk),
        .i_wr_en      (key_wr_en),
        .i_wr_frame   (key_wr_frame),
        .i_wr_page    (r_page),
        .i_rd_row     (r_rd_row),
        .i_row_pinned (r_pinned[{r_cmp_row, LANE_W'(0)} +: LANES]),
        .i_key        (r_page),
        .o_match      (match)
    );

    pfpm_stack u_stack (
        .i_clk        (i_clk),
        .i_push       (stk_push),
        .i_push_addr  (r_free_depth[FRAME_W-1:0]),
        .i_push_frame (r_fi),
        .i_rd_addr    (depth_dec[FRAME_W-1:0]),
        .o_rd_frame   (stk_rd_frame)
    );

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_page         = r_page;
        n_fi           = r_fi;
        n_rd_row       = r_rd_row;
        n_cmp_row      = r_cmp_row;
        n_cmp_vld      = r_cmp_vld;
        n_pinned       = r_pinned;
        n_free_depth   = r_free_depth;
        n_alloc        = r_alloc;
        n_pinned_count = r_pinned_count;
        n_max_pages    = r_max_pages;
        n_res_status   = r_res_status;
        n_res_frame    = r_res_frame;
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_frame    = r_out_frame;
        key_wr_en      = 1'b0;
        key_wr_frame   = r_fi;
        stk_push       = 1'b0;

        if (i_cfg.valid) begin
            n_max_pages = i_cfg.max_pages;
        end

        // drop the result once the sink takes it
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_cmd     = i_req.cmd;
                    n_page    = i_req.page_number;
                    n_fi      = i_req.frame_index;
                    n_rd_row  = '0;
                    n_cmp_vld = 1'b0;
                    case (i_req.cmd)
                        CMD_GET, CMD_FETCH: n_state = S_SCAN;
                        CMD_UNPIN:          n_state = S_UNPIN;
                        default: begin
                            n_res_status = ST_NOT_FOUND;
                            n_res_frame  = '0;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // advance the read row; compare the row read last cycle
                n_rd_row  = r_rd_row + ROW_W'(1);
                n_cmp_row = r_rd_row;
                n_cmp_vld = 1'b1;
                if (r_cmp_vld) begin
                    if (match.hit) begin
                        n_res_status = ST_HIT;
                        n_res_frame  = {r_cmp_row, match.lane};
                        n_state      = S_DONE;
                    end else if (r_cmp_row == ROW_LAST) begin
                        if (r_cmd == CMD_FETCH) begin
                            n_state = S_MISS;
                        end else begin
                            n_res_status = ST_NOT_FOUND;
                            n_res_frame  = '0;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_MISS: begin
                n_state = S_DONE;
                if (r_free_depth != '0) begin
                    // reuse the most recently unpinned frame
                    key_wr_en              = 1'b1;
                    key_wr_frame           = stk_rd_frame;
                    n_pinned[stk_rd_frame] = 1'b1;
                    n_free_depth           = depth_dec;
                    n_pinned_count         = r_pinned_count + CNT_W'(1);
                    n_res_status           = ST_REUSED;
                    n_res_frame            = stk_rd_frame;
                end else if (r_alloc >= limit) begin
                    n_res_status = ST_FULL;
                    n_res_frame  = '0;
                end else begin
                    key_wr_en                          = 1'b1;
                    key_wr_frame                       = r_alloc[FRAME_W-1:0];
                    n_pinned[r_alloc[FRAME_W-1:0]]     = 1'b1;
                    n_alloc                            = r_alloc + CNT_W'(1);
                    n_pinned_count                     = r_pinned_count + CNT_W'(1);
                    n_res_status                       = ST_NEW;
                    n_res_frame                        = r_alloc[FRAME_W-1:0];
                end
            end
            S_UNPIN: begin
                n_state = S_DONE;
                if (({1'b0, r_fi} >= r_alloc) || !r_pinned[r_fi] ||
                    (r_free_depth >= CNT_W'(FRAMES))) begin
                    n_res_status = ST_UNPIN_ERR;
                    n_res_frame  = '0;
                end else begin
                    n_pinned[r_fi] = 1'b0;
                    if (r_pinned_count != '0) begin
                        n_pinned_count = r_pinned_count - CNT_W'(1);
                    end
                    stk_push     = 1'b1;
                    n_free_depth = r_free_depth + CNT_W'(1);
                    n_res_status = ST_UNPINNED;
                    n_res_frame  = r_fi;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_frame  = r_res_frame;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cmp_vld      <= 1'b0;
            r_pinned       <= '0;
            r_free_depth   <= '0;
            r_alloc        <= '0;
            r_pinned_count <= '0;
            r_max_pages    <= MAX_PAGES_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cmp_vld      <= n_cmp_vld;
            r_pinned       <= n_pinned;
            r_free_depth   <= n_free_depth;
            r_alloc        <= n_alloc;
            r_pinned_count <= n_pinned_count;
            r_max_pages    <= n_max_pages;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_page       <= n_page;
        r_fi         <= n_fi;
        r_rd_row     <= n_rd_row;
        r_cmp_row    <= n_cmp_row;
        r_res_status <= n_res_status;
        r_res_frame  <= n_res_frame;
        r_out_status <= n_out_status;
        r_out_frame  <= n_out_frame;
    end

    a_pin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pinned_count == CNT_W'($countones(r_pinned)))
        else $error("pinned count out of step with pin bits");

    a_frames_accounted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_free_depth + r_pinned_count == r_alloc))
        else $error("allocated frames neither pinned nor free");

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= CNT_W'(FRAMES))
        else $error("allocation beyond pool size");

    a_new_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (r_res_status == ST_NEW || r_res_status == ST_REUSED ||
         r_res_status == ST_HIT)) |-> r_pinned[r_res_frame])
        else $error("reported frame is not pinned");

endmodule
